[design/mcd_pkg.sv]
// Shared types, register indexes and tables for the MPEG coefficient dequantizer.
package mcd_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 7;

   localparam logic [CsrIndexWidth-1:0] CSR_STANDARD_MODE         = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_NONLINEAR_QSCALE      = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_INTRA_MISMATCH_ENABLE = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_LUMA_DC_SCALE         = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_CHROMA_DC_SCALE       = 3'd4;

   localparam logic [6:0] DC_SCALE_RESET = 7'd8;

   typedef struct packed {
      logic signed [11:0] level;
      logic [5:0]         position;
      logic [7:0]         weight;
      logic [4:0]         quant_scale_code;
      logic               is_intra;
      logic               is_chroma;
      logic               last_in_block;
   } req_type;

   typedef struct packed {
      logic signed [15:0] value;
      logic [5:0]         out_position;
      logic               block_end;
      logic               flip_lsb_63;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_FIN
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic step1;
      logic step2;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } status_type;

   // MPEG-2 non-linear quantizer scale
   function automatic logic [6:0] nl_scale(input logic [4:0] code);
      logic [6:0] s;
      case (code)
         5'd0:  s = 7'd0;
         5'd1:  s = 7'd1;
         5'd2:  s = 7'd2;
         5'd3:  s = 7'd3;
         5'd4:  s = 7'd4;
         5'd5:  s = 7'd5;
         5'd6:  s = 7'd6;
         5'd7:  s = 7'd7;
         5'd8:  s = 7'd8;
         5'd9:  s = 7'd10;
         5'd10: s = 7'd12;
         5'd11: s = 7'd14;
         5'd12: s = 7'd16;
         5'd13: s = 7'd18;
         5'd14: s = 7'd20;
         5'd15: s = 7'd22;
         5'd16: s = 7'd24;
         5'd17: s = 7'd28;
         5'd18: s = 7'd32;
         5'd19: s = 7'd36;
         5'd20: s = 7'd40;
         5'd21: s = 7'd44;
         5'd22: s = 7'd48;
         5'd23: s = 7'd52;
         5'd24: s = 7'd56;
         5'd25: s = 7'd64;
         5'd26: s = 7'd72;
         5'd27: s = 7'd80;
         5'd28: s = 7'd88;
         5'd29: s = 7'd96;
         5'd30: s = 7'd104;
         5'd31: s = 7'd112;
         default: s = 7'd0;
      endcase
      return s;
   endfunction

endpackage

[design/mcd_ctrl.sv]
// Sequencer for the dequantizer: capture, two multiply steps, result load.
module mcd_ctrl
   import mcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.step1 = 1'b1;
            state_in  = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.step2 = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            // wait here while the output register still holds an untaken word
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/mcd_datapath.sv]
// Dequantizer datapath: config registers, multiply chain, rounding, parity, output register.
module mcd_datapath
   import mcd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  req_type                  req_data,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data
);

   // configuration
   logic       standard_mode_ff;
   logic       nonlinear_qscale_ff;
   logic       intra_mismatch_enable_ff;
   logic [6:0] luma_dc_scale_ff;
   logic [6:0] chroma_dc_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         standard_mode_ff         <= 1'b0;
         nonlinear_qscale_ff      <= 1'b0;
         intra_mismatch_enable_ff <= 1'b0;
         luma_dc_scale_ff         <= DC_SCALE_RESET;
         chroma_dc_scale_ff       <= DC_SCALE_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_STANDARD_MODE:         standard_mode_ff         <= csr_wdata[0];
            CSR_NONLINEAR_QSCALE:      nonlinear_qscale_ff      <= csr_wdata[0];
            CSR_INTRA_MISMATCH_ENABLE: intra_mismatch_enable_ff <= csr_wdata[0];
            CSR_LUMA_DC_SCALE:         luma_dc_scale_ff         <= csr_wdata;
            CSR_CHROMA_DC_SCALE:       chroma_dc_scale_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // capture stage: magnitude, scale and multiplier operands
   logic        neg_in;
   logic [11:0] mag_in;
   logic        dc_in;
   logic [6:0]  qs_in;
   logic [12:0] fa_in;
   logic [6:0]  fb_in;
   logic        mm_in;

   always_comb begin
      neg_in = req_data.level[11];
      mag_in = neg_in ? (12'd0 - req_data.level) : req_data.level;
      dc_in  = req_data.is_intra && (req_data.position == 6'd0);
      if (standard_mode_ff) begin
         qs_in = nonlinear_qscale_ff ? nl_scale(req_data.quant_scale_code)
                                     : {1'b0, req_data.quant_scale_code, 1'b0};
      end else begin
         qs_in = {2'b00, req_data.quant_scale_code};
      end
      if (dc_in) begin
         fa_in = {1'b0, mag_in};
         fb_in = req_data.is_chroma ? chroma_dc_scale_ff : luma_dc_scale_ff;
      end else begin
         fa_in = req_data.is_intra ? {1'b0, mag_in} : {mag_in, 1'b1};
         fb_in = qs_in;
      end
      mm_in = standard_mode_ff && (!req_data.is_intra || intra_mismatch_enable_ff);
   end

   logic        neg_ff;
   logic        zero_ff;
   logic        dc_ff;
   logic        intra_ff;
   logic        mpeg2_ff;
   logic        mm_ff;
   logic        last_ff;
   logic [5:0]  pos_ff;
   logic [7:0]  weight_ff;
   logic [12:0] fa_ff;
   logic [6:0]  fb_ff;
   logic [19:0] prod1_ff;
   logic [27:0] prod2_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         neg_ff    <= neg_in;
         zero_ff   <= (mag_in == 12'd0);
         dc_ff     <= dc_in;
         intra_ff  <= req_data.is_intra;
         mpeg2_ff  <= standard_mode_ff;
         mm_ff     <= mm_in;
         last_ff   <= req_data.last_in_block;
         pos_ff    <= req_data.position;
         weight_ff <= req_data.weight;
         fa_ff     <= fa_in;
         fb_ff     <= fb_in;
      end
      if (cmd.step1) begin
         prod1_ff <= {7'd0, fa_ff} * {13'd0, fb_ff};
      end
      if (cmd.step2) begin
         prod2_ff <= dc_ff ? {8'd0, prod1_ff} : ({8'd0, prod1_ff} * {20'd0, weight_ff});
      end
   end

   // finish: shift, MPEG-1 odd forcing, sign, mismatch parity
   logic        parity_ff;
   logic        parity_in;
   logic [2:0]  shift_amt;
   logic [27:0] shifted;
   logic [15:0] mag16;
   logic [15:0] val16;
   logic        par_next;
   logic        flip;

   always_comb begin
      case ({intra_ff, mpeg2_ff})
         2'b10:   shift_amt = 3'd3;
         2'b11:   shift_amt = 3'd4;
         2'b00:   shift_amt = 3'd4;
         2'b01:   shift_amt = 3'd5;
         default: shift_amt = 3'd4;
      endcase
      shifted = prod2_ff >> shift_amt;
      if (dc_ff) begin
         mag16 = prod2_ff[15:0];
      end else if (zero_ff) begin
         mag16 = 16'd0;
      end else if (!mpeg2_ff) begin
         mag16 = (shifted[15:0] - 16'd1) | 16'd1;
      end else begin
         mag16 = shifted[15:0];
      end
      val16     = neg_ff ? (16'd0 - mag16) : mag16;
      par_next  = mm_ff ? (parity_ff ^ val16[0]) : parity_ff;
      flip      = last_ff && mm_ff && par_next;
      parity_in = parity_ff;
      if (cmd.finish) begin
         parity_in = last_ff ? 1'b1 : par_next;
      end
   end

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.value        <= val16;
         rsp_ff.out_position <= pos_ff;
         rsp_ff.block_end    <= last_ff;
         rsp_ff.flip_lsb_63  <= flip;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

[design/mpeg_coefficient_dequantizer_unit.sv]
// Top level of the MPEG-1/MPEG-2 coefficient dequantizer.
//
// Input channel (req_*): one word per coefficient with level, raster position,
//   matrix weight, scale code and intra/chroma/last marks, valid/ready handshake.
// Result channel (rsp_*): one word per input word, in order: 16-bit wrapped value,
//   position, block end mark and the mismatch-control flip of coefficient 63.
// Config port (csr_*): write-only; csr_wen with csr_index/csr_wdata writes one
//   register in a cycle. Write only while no word is in flight.
// Sequence: the accepting edge captures the operands, then come the first multiply,
//   the second multiply and the result load, which waits while the output is full.
// Flow: the single sequencer walks each word through the two-step multiply chain
//   and the result load before the next word is taken.
// Stall: the output register holds the finished word; the next word is still
//   accepted and computed, and waits in the last step until rsp_ready frees it.
// Reset: synchronous, clears config to defaults (MPEG-1, DC scales of 8), the
//   mismatch parity to 1 and both channels to empty.
module mpeg_coefficient_dequantizer_unit
   import mcd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_wen,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencer: one word at a time
   mcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, config registers, parity and output register
   mcd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a captured word blocks the input until it has been loaded into the output
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a word is in flight");

   // flip mark only ever accompanies the last word of a block
   a_flip_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.block_end || !rsp_data.flip_lsb_63))
      else $error("flip_lsb_63 set on a word that is not a block end");

   // sequencer issues at most one step per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.step1, cmd.step2, cmd.finish}))
      else $error("more than one sequencer command in a cycle");

   // a finished word never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over an untaken word");

endmodule
